>>> rtl/range_jump_classifier_assert.svh
// assertion macros used by the checker file
`ifndef RANGE_JUMP_CLASSIFIER_ASSERT_SVH
`define RANGE_JUMP_CLASSIFIER_ASSERT_SVH

// consequent must hold in the cycle after the antecedent
`define RJC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rjc assertion failed");

// condition must hold at every edge out of reset
`define RJC_ASSERT_ALWAYS(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("rjc assertion failed");

`endif

>>> rtl/rjc_pkg.sv
// shared constants and codes for the range jump classifier
package rjc_pkg;

	localparam int MAX_POINTS   = 512;
	localparam int BIG_WINDOW   = 5;
	localparam int SMALL_WINDOW = 2;

	localparam int ADDR_W  = $clog2(MAX_POINTS);
	localparam int IDX_W   = 9;
	localparam int LEN_W   = 10;
	localparam int RANGE_W = 16;
	localparam int THR_W   = 16;
	localparam int KIND_W  = 2;
	localparam int CFG_W   = 16;
	localparam int CFG_A_W = 2;

	localparam int IN_DATA_W  = 32;
	localparam int OUT_DATA_W = 16;

	localparam int SUM_W = RANGE_W + 4;
	localparam int CMP_W = RANGE_W + 8;
	localparam int CNT_W = $clog2(2 * BIG_WINDOW + 2);

	localparam int BIG_MULT   = 3 * BIG_WINDOW;
	localparam int SMALL_MULT = 3 * SMALL_WINDOW;

	// register indexes
	localparam logic [CFG_A_W-1:0] REG_SCAN_LENGTH = 2'd0;
	localparam logic [CFG_A_W-1:0] REG_FIND_BIG    = 2'd1;
	localparam logic [CFG_A_W-1:0] REG_BIG_THR     = 2'd2;
	localparam logic [CFG_A_W-1:0] REG_SMALL_THR   = 2'd3;

	// input function codes
	localparam logic FUNC_LOAD     = 1'b0;
	localparam logic FUNC_CLASSIFY = 1'b1;

	// result kinds
	localparam logic [KIND_W-1:0] KIND_NONE    = 2'd0;
	localparam logic [KIND_W-1:0] KIND_BIG     = 2'd1;
	localparam logic [KIND_W-1:0] KIND_SMALL   = 2'd2;
	localparam logic [KIND_W-1:0] KIND_OUTLIER = 2'd3;

endpackage

>>> rtl/rjc_ram.sv
// single-port synchronous ram with registered read data
module rjc_ram #(
	parameter int DEPTH = 512,
	parameter int WIDTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

>>> rtl/range_jump_classifier.sv
// top level of the range jump classifier
//
// input channel s_*: one beat either loads a range sample (s_tuser = 0) into
// the scan store or asks for the classification of a point (s_tuser = 1).
// output channel m_*: one beat per classify, carrying the point index and
// the jump kind; loads produce no output beat.
// config port cfg_*: the user must write it only while the block is idle; the block does not enforce this.
//
// a load leaves the block idle and the next beat can follow right behind it.
// a classify reads its samples one per cycle from the single-port store:
// the point, its neighbor, then alternating pre/post window samples, ten of
// them with big detection on and four with it off. after the reads a classify
// passes a drain state for the read latency and then the evaluation state,
// which waits for a free output slot, before the next beat is taken; a point
// outside the scan goes from accept straight to the evaluation state.
// the single memory port sets this read sequence.
//
// reset clears the control state and the output valid and restores the
// register defaults; the store contents stay undefined until loaded.
// a stalled receiver holds the result in the output register; the block
// still takes new input beats until a second result would need that slot.
module range_jump_classifier
	import rjc_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	// input stream
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_DATA_W-1:0]   s_tdata,   // point_index [8:0], range_value [24:9]
	input  logic                   s_tuser,   // func
	// output stream
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_DATA_W-1:0]  m_tdata,   // point_index_out [8:0]
	output logic [KIND_W-1:0]      m_tuser,   // jump_kind [1:0]
	// config write port
	input  logic                   cfg_we,
	input  logic [CFG_A_W-1:0]     cfg_addr,
	input  logic [CFG_W-1:0]       cfg_wdata
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_DRAIN,
		ST_EVAL
	} state_t;

	localparam logic [CNT_W-1:0] LAST_BIG   = CNT_W'(2 * BIG_WINDOW + 1);
	localparam logic [CNT_W-1:0] LAST_SMALL = CNT_W'(2 * SMALL_WINDOW + 1);

	// config registers
	logic [LEN_W-1:0]   scan_length_q;
	logic               find_big_q;
	logic [THR_W-1:0]   big_thr_q;
	logic [THR_W-1:0]   small_thr_q;

	// sequencer state
	state_t             state_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [CNT_W-1:0]   last_q;
	logic               skip_q;
	logic [IDX_W-1:0]   idx_q;
	logic [ADDR_W-1:0]  center_q;
	logic [LEN_W-1:0]   n_q;
	logic [ADDR_W-1:0]  pre_ptr_q;
	logic [ADDR_W-1:0]  post_ptr_q;

	// read return tag
	logic               rd_valid_s1;
	logic [CNT_W-1:0]   rd_cnt_s1;

	// gathered samples and window sums
	logic [RANGE_W-1:0] cur_q;
	logic [RANGE_W-1:0] nxt_q;
	logic [SUM_W-1:0]   pre_big_q;
	logic [SUM_W-1:0]   post_big_q;
	logic [SUM_W-1:0]   pre_small_q;
	logic [SUM_W-1:0]   post_small_q;

	// output register
	logic               m_valid_q;
	logic [IDX_W-1:0]   m_idx_q;
	logic [KIND_W-1:0]  m_kind_q;

	// input beat fields
	logic [IDX_W-1:0]   in_idx;
	logic [RANGE_W-1:0] in_range;
	logic               in_acc;
	logic               out_free;

	// memory port
	logic               ram_we;
	logic [ADDR_W-1:0]  ram_addr;
	logic [RANGE_W-1:0] ram_rdata;

	// derived values
	logic [LEN_W-1:0]   n_eff;
	logic [LEN_W-1:0]   idx_inc;
	logic [ADDR_W-1:0]  pre_next;
	logic [ADDR_W-1:0]  post_next;
	logic [CNT_W-1:0]   win_pos;
	logic [RANGE_W-1:0] step;
	logic               big_hit;
	logic               small_hit;
	logic [SUM_W-1:0]   diff_big;
	logic [SUM_W-1:0]   diff_small;
	logic [CMP_W-1:0]   lhs_big;
	logic [CMP_W-1:0]   lhs_small;
	logic [CMP_W-1:0]   rhs_big;
	logic [CMP_W-1:0]   rhs_small;
	logic [KIND_W-1:0]  eval_kind;

	assign in_idx   = s_tdata[IDX_W-1:0];
	assign in_range = s_tdata[IDX_W +: RANGE_W];
	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign out_free = !m_valid_q || m_tready;

	assign m_tvalid = m_valid_q;
	assign m_tdata  = OUT_DATA_W'(m_idx_q);
	assign m_tuser  = m_kind_q;

	// effective scan length: saturate to the store, zero acts as one
	always_comb begin
		if (scan_length_q > LEN_W'(MAX_POINTS)) begin
			n_eff = LEN_W'(MAX_POINTS);
		end else if (scan_length_q == '0) begin
			n_eff = LEN_W'(1);
		end else begin
			n_eff = scan_length_q;
		end
	end

	assign idx_inc = LEN_W'(in_idx) + LEN_W'(1);

	// circular walk one step back and one step ahead
	assign pre_next  = (pre_ptr_q == '0) ? ADDR_W'(n_q - LEN_W'(1)) : pre_ptr_q - ADDR_W'(1);
	assign post_next = ((LEN_W'(post_ptr_q) + LEN_W'(1)) == n_q) ? '0
		: post_ptr_q + ADDR_W'(1);

	// memory address: writes on load beats, read sequence during classify
	always_comb begin
		ram_we   = 1'b0;
		ram_addr = ADDR_W'(in_idx);
		case (state_q)
			ST_IDLE: begin
				ram_we = in_acc && (s_tuser == FUNC_LOAD)
					&& (LEN_W'(in_idx) < LEN_W'(MAX_POINTS));
			end
			ST_ISSUE: begin
				if (cnt_q == CNT_W'(0)) begin
					ram_addr = ADDR_W'(idx_q);
				end else if (cnt_q == CNT_W'(1)) begin
					ram_addr = center_q;
				end else if (!cnt_q[0]) begin
					ram_addr = pre_next;
				end else begin
					ram_addr = post_next;
				end
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	rjc_ram #(
		.DEPTH (MAX_POINTS),
		.WIDTH (RANGE_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (in_range),
		.rdata (ram_rdata)
	);

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_length_q <= LEN_W'(MAX_POINTS);
			find_big_q    <= 1'b1;
			big_thr_q     <= '0;
			small_thr_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_SCAN_LENGTH: scan_length_q <= cfg_wdata[LEN_W-1:0];
				REG_FIND_BIG:    find_big_q    <= cfg_wdata[0];
				REG_BIG_THR:     big_thr_q     <= cfg_wdata[THR_W-1:0];
				REG_SMALL_THR:   small_thr_q   <= cfg_wdata[THR_W-1:0];
				default:         find_big_q    <= find_big_q;
			endcase
		end
	end

	// evaluation: step test first, then the averaged window test
	assign step      = (cur_q > nxt_q) ? cur_q - nxt_q : nxt_q - cur_q;
	assign big_hit   = find_big_q && (step > big_thr_q);
	assign small_hit = step > small_thr_q;

	assign diff_big   = (pre_big_q > post_big_q) ? pre_big_q - post_big_q
		: post_big_q - pre_big_q;
	assign diff_small = (pre_small_q > post_small_q) ? pre_small_q - post_small_q
		: post_small_q - pre_small_q;
	assign lhs_big    = CMP_W'({diff_big, 2'b00});
	assign lhs_small  = CMP_W'({diff_small, 2'b00});
	assign rhs_big    = CMP_W'(big_thr_q) * CMP_W'(BIG_MULT);
	assign rhs_small  = CMP_W'(small_thr_q) * CMP_W'(SMALL_MULT);

	always_comb begin
		if (skip_q) begin
			eval_kind = KIND_NONE;
		end else if (big_hit) begin
			eval_kind = (lhs_big > rhs_big) ? KIND_BIG : KIND_OUTLIER;
		end else if (small_hit) begin
			eval_kind = (lhs_small > rhs_small) ? KIND_SMALL : KIND_OUTLIER;
		end else begin
			eval_kind = KIND_NONE;
		end
	end

	// sequencer with output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			last_q      <= '0;
			skip_q      <= 1'b0;
			rd_valid_s1 <= 1'b0;
			m_valid_q   <= 1'b0;
		end else begin
			rd_valid_s1 <= (state_q == ST_ISSUE);
			// a new result fills the slot, a taken one frees it
			if (state_q == ST_EVAL && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc && (s_tuser == FUNC_CLASSIFY)) begin
						cnt_q  <= '0;
						last_q <= find_big_q ? LAST_BIG : LAST_SMALL;
						if (LEN_W'(in_idx) >= n_eff) begin
							skip_q  <= 1'b1;
							state_q <= ST_EVAL;
						end else begin
							skip_q  <= 1'b0;
							state_q <= ST_ISSUE;
						end
					end
				end
				ST_ISSUE: begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == last_q) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_EVAL;
				end
				ST_EVAL: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload of the sequencer: point, wrap bounds, window pointers, result
	always_ff @(posedge clk) begin
		rd_cnt_s1 <= cnt_q;
		if (in_acc && (s_tuser == FUNC_CLASSIFY)) begin
			idx_q      <= in_idx;
			n_q        <= n_eff;
			center_q   <= (idx_inc == n_eff) ? '0 : ADDR_W'(idx_inc);
			pre_ptr_q  <= (idx_inc == n_eff) ? '0 : ADDR_W'(idx_inc);
			post_ptr_q <= (idx_inc == n_eff) ? '0 : ADDR_W'(idx_inc);
		end
		if (state_q == ST_ISSUE && cnt_q >= CNT_W'(2)) begin
			if (!cnt_q[0]) begin
				pre_ptr_q <= pre_next;
			end else begin
				post_ptr_q <= post_next;
			end
		end
		if (state_q == ST_EVAL && out_free) begin
			m_idx_q  <= idx_q;
			m_kind_q <= eval_kind;
		end
	end

	// window position of the returning sample, counted from zero
	assign win_pos = (rd_cnt_s1 - CNT_W'(2)) >> 1;

	// gather returning samples into the point pair and the window sums
	always_ff @(posedge clk) begin
		if (in_acc) begin
			pre_big_q    <= '0;
			post_big_q   <= '0;
			pre_small_q  <= '0;
			post_small_q <= '0;
		end else if (rd_valid_s1) begin
			if (rd_cnt_s1 == CNT_W'(0)) begin
				cur_q <= ram_rdata;
			end else if (rd_cnt_s1 == CNT_W'(1)) begin
				nxt_q <= ram_rdata;
			end else if (!rd_cnt_s1[0]) begin
				pre_big_q <= pre_big_q + SUM_W'(ram_rdata);
				if (win_pos < CNT_W'(SMALL_WINDOW)) begin
					pre_small_q <= pre_small_q + SUM_W'(ram_rdata);
				end
			end else begin
				post_big_q <= post_big_q + SUM_W'(ram_rdata);
				if (win_pos < CNT_W'(SMALL_WINDOW)) begin
					post_small_q <= post_small_q + SUM_W'(ram_rdata);
				end
			end
		end
	end

endmodule

>>> rtl/rjc_checker.sv
// port-level checks for the range jump classifier and their binding
`include "range_jump_classifier_assert.svh"

module rjc_checker
	import rjc_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  s_tvalid,
	input logic                  s_tready,
	input logic [IN_DATA_W-1:0]  s_tdata,
	input logic                  s_tuser,
	input logic                  m_tvalid,
	input logic                  m_tready,
	input logic [OUT_DATA_W-1:0] m_tdata,
	input logic [KIND_W-1:0]     m_tuser
);

	// a stalled result holds
	`RJC_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))

	// a classify beat closes the input until its result is formed
	`RJC_ASSERT_NEXT(a_classify_busy, clk, arst_n, s_tvalid && s_tready && (s_tuser == FUNC_CLASSIFY), !s_tready)

	// a load beat leaves the input open for the next beat
	`RJC_ASSERT_NEXT(a_load_fast, clk, arst_n, s_tvalid && s_tready && (s_tuser == FUNC_LOAD), s_tready)

	// index field fills only its own bits
	`RJC_ASSERT_ALWAYS(a_pad_zero, clk, arst_n, !m_tvalid || (m_tdata[OUT_DATA_W-1:IDX_W] == '0))

endmodule

bind range_jump_classifier rjc_checker u_rjc_checker (.*);
